// ===== hdl/dhti_pkg.sv =====
// ----------------------------------------------------------------------------
// dhti_pkg
// shared constants and types for the double hashing insert block
// ----------------------------------------------------------------------------
package dhti_pkg;

	// table geometry, size must be prime
	localparam int TABLE_SIZE = 11;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int TRY_W      = $clog2(TABLE_SIZE + 1);

	// key and result field widths
	localparam int KEY_W     = 31;
	localparam int SLOT_OUT_W = 4;
	localparam int PROBE_OUT_W = 4;
	localparam int OUTCOME_W = 2;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 16;

	// remainder unit: reciprocal multiply, then multiply back and subtract
	localparam int MOD_CYCLES = 2;
	localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

	// quotient = (key * recip) >> shift, exact for every key below 2^KEY_W
	localparam int HOME_SH    = KEY_W + $clog2(TABLE_SIZE);
	localparam int STEP_SH    = KEY_W + $clog2(TABLE_SIZE - 1);
	localparam int RECIP_W    = KEY_W + 1;
	localparam int PROD_W     = KEY_W + RECIP_W;
	localparam int HOME_QUO_W = PROD_W - HOME_SH;
	localparam int STEP_QUO_W = PROD_W - STEP_SH;

	localparam logic [RECIP_W-1:0] HOME_RECIP = RECIP_W'(
		((64'd1 << HOME_SH) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
	localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(
		((64'd1 << STEP_SH) + 64'(TABLE_SIZE - 2)) / 64'(TABLE_SIZE - 1));
	localparam logic [KEY_W-1:0]   HOME_DIV   = KEY_W'(TABLE_SIZE);
	localparam logic [KEY_W-1:0]   STEP_DIV   = KEY_W'(TABLE_SIZE - 1);

	localparam logic [SLOT_W:0] SIZE_V     = (SLOT_W + 1)'(TABLE_SIZE);
	localparam logic [TRY_W-1:0] TRY_LIMIT = TRY_W'(TABLE_SIZE);

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_INSERTED  = 2'd0,
		OUT_DUPLICATE = 2'd1,
		OUT_FULL      = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_START,
		ST_PROBE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_key;
		logic hash_en;
		logic probe_start;
		logic probe_step;
		logic commit;
	} dhti_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_done;
		logic probe_end;
		logic out_free;
	} dhti_status_t;

endpackage

// ===== hdl/dhti_table.sv =====
// ----------------------------------------------------------------------------
// dhti_table
// key store and occupancy marks, one read and one write port, registered read
// ----------------------------------------------------------------------------
module dhti_table
	import dhti_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  logic [KEY_W-1:0]  wr_key,
	output logic [KEY_W-1:0]  rd_key_q,
	output logic              rd_occ_q
);

	logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] occ_q;

	// key store, contents undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key_q <= key_mem[rd_addr];
	end

	// occupancy marks, all free after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			rd_occ_q <= 1'b0;
		end else begin
			if (wr_en) begin
				occ_q[wr_addr] <= 1'b1;
			end
			rd_occ_q <= occ_q[rd_addr];
		end
	end

endmodule

// ===== hdl/dhti_dp.sv =====
// ----------------------------------------------------------------------------
// dhti_dp
// datapath: key remainders, probe sequence, table access and result register
// ----------------------------------------------------------------------------
module dhti_dp
	import dhti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dhti_cmd_t             cmd,
	output dhti_status_t          status,
	input  logic [KEY_W-1:0]      in_key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUTCOME_W-1:0]  out_outcome,
	output logic [SLOT_OUT_W-1:0] out_slot,
	output logic [PROBE_OUT_W-1:0] out_probes
);

	logic [KEY_W-1:0]      key_q;
	logic [MOD_CNT_W-1:0]  mod_cnt_q;
	logic [PROD_W-1:0]     prod_home;
	logic [PROD_W-1:0]     prod_step;
	logic [HOME_QUO_W-1:0] quo_home_q;
	logic [STEP_QUO_W-1:0] quo_step_q;
	logic [KEY_W-1:0]      back_home;
	logic [KEY_W-1:0]      back_step;
	logic [KEY_W-1:0]      diff_home;
	logic [KEY_W-1:0]      diff_step;
	logic [SLOT_W-1:0]    rem_home_q;
	logic [SLOT_W-1:0]    rem_step_q;
	logic [SLOT_W-1:0]    step;
	logic [SLOT_W-1:0]    pos_q;
	logic [SLOT_W-1:0]    pos_next;
	logic [SLOT_W:0]      pos_sum;
	logic [TRY_W-1:0]     tries_q;
	logic [SLOT_W-1:0]    rd_addr;
	logic [KEY_W-1:0]     rd_key;
	logic                 rd_occ;
	logic                 full;
	outcome_t             outcome;
	logic                 out_valid_q;
	outcome_t             out_outcome_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [PROBE_OUT_W-1:0] out_probes_q;

	// first step: quotients by reciprocal multiply
	assign prod_home = PROD_W'(key_q) * PROD_W'(HOME_RECIP);
	assign prod_step = PROD_W'(key_q) * PROD_W'(STEP_RECIP);

	// second step: remainder = key - quotient * divisor
	assign back_home = KEY_W'(quo_home_q) * HOME_DIV;
	assign back_step = KEY_W'(quo_step_q) * STEP_DIV;
	assign diff_home = key_q - back_home;
	assign diff_step = key_q - back_step;

	// remainders settle on the second hash step
	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= in_key;
		end
		if (cmd.hash_en) begin
			quo_home_q <= prod_home[PROD_W-1:HOME_SH];
			quo_step_q <= prod_step[PROD_W-1:STEP_SH];
			rem_home_q <= diff_home[SLOT_W-1:0];
			rem_step_q <= diff_step[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
		end else if (cmd.load_key) begin
			mod_cnt_q <= '0;
		end else if (cmd.hash_en) begin
			mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
		end
	end

	// probe arithmetic, step stays below the table size
	assign step     = rem_step_q + SLOT_W'(1);
	assign pos_sum  = {1'b0, pos_q} + {1'b0, step};
	assign pos_next = (pos_sum >= SIZE_V) ? SLOT_W'(pos_sum - SIZE_V) : pos_sum[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.probe_start) begin
			pos_q   <= rem_home_q;
			tries_q <= '0;
		end else if (cmd.probe_step) begin
			pos_q   <= pos_next;
			tries_q <= tries_q + TRY_W'(1);
		end
	end

	always_comb begin
		if (cmd.probe_start) begin
			rd_addr = rem_home_q;
		end else if (cmd.probe_step) begin
			rd_addr = pos_next;
		end else begin
			rd_addr = pos_q;
		end
	end

	dhti_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.wr_en    (cmd.commit && (outcome == OUT_INSERTED)),
		.wr_addr  (pos_q),
		.wr_key   (key_q),
		.rd_key_q (rd_key),
		.rd_occ_q (rd_occ)
	);

	// probe outcome for the slot now read
	assign full = (tries_q == TRY_LIMIT);

	always_comb begin
		if (full) begin
			outcome = OUT_FULL;
		end else if (!rd_occ) begin
			outcome = OUT_INSERTED;
		end else begin
			outcome = OUT_DUPLICATE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_outcome_q <= outcome;
			out_slot_q    <= full ? '0 : SLOT_OUT_W'(pos_q);
			out_probes_q  <= PROBE_OUT_W'(tries_q);
		end
	end

	assign status.hash_done = (mod_cnt_q == MOD_CNT_W'(MOD_CYCLES - 1));
	assign status.probe_end = full || !rd_occ || (rd_key == key_q);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_outcome = out_outcome_q;
	assign out_slot    = out_slot_q;
	assign out_probes  = out_probes_q;

endmodule

// ===== hdl/dhti_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhti_ctrl
// controller: sequences key intake, remainder cycles and table probes
// ----------------------------------------------------------------------------
module dhti_ctrl
	import dhti_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  dhti_status_t status,
	output dhti_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (status.hash_done) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (status.probe_end && status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_key = in_valid;
			end
			ST_HASH: begin
				cmd.hash_en = 1'b1;
			end
			ST_START: begin
				cmd.probe_start = 1'b1;
			end
			ST_PROBE: begin
				cmd.commit     = status.probe_end && status.out_free;
				cmd.probe_step = !status.probe_end;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/double_hash_table_insert.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_insert
// open-addressed table insert with double hashing, one result per request
// ----------------------------------------------------------------------------
// Each request carries a 31-bit key that is inserted into a table of
// TABLE_SIZE slots (prime, 11 here). The home slot is key mod size and the
// step is 1 + key mod (size-1); probes walk home + i*step mod size until a
// free slot (key stored, outcome inserted), a slot holding the same key
// (outcome duplicate) or size extra probes (outcome full, slot 0). Requests
// are handled one at a time. After a request is taken, the remainder unit
// does a reciprocal multiply, then a multiply back and subtract, the home
// slot is then loaded, and the probe loop looks at the slots one at a time
// through the registered table read until it ends. The result sits in an
// output register, so a new request is taken as soon as the probe loop is
// done, even while the result waits; the probe loop of that next request
// holds its result until the register is free.
// The occupancy marks are cleared at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_hash_table_insert
	import dhti_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [30:0] key, [31] zero fill
	// result channel
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // [1:0] outcome, [5:2] slot, [9:6] probes
);

	dhti_cmd_t             cmd;
	dhti_status_t          status;
	logic [OUTCOME_W-1:0]  outcome;
	logic [SLOT_OUT_W-1:0] slot;
	logic [PROBE_OUT_W-1:0] probes;

	// sequencing of intake, remainder and probe phases
	dhti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// remainders, probe walk, table and result register
	dhti_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_key      (s_tdata[KEY_W-1:0]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_outcome (outcome),
		.out_slot    (slot),
		.out_probes  (probes)
	);

	// result fields packed from bit 0 up, zero filled to whole bytes
	assign m_tdata = M_DATA_W'({probes, slot, outcome});

endmodule
